>>> src/der_tlv_pkg.sv
`timescale 1ns / 1ps
// Package for the DER TLV header parser: word widths, error codes and the
// layout of the result word. Used by der_tlv_header_parser and its checker.
package der_tlv_pkg;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;

  // Error codes carried in the result.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_HIGH_TAG  = 3'd2;
  localparam logic [2:0] ERR_COUNT     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_ZERO      = 3'd5;
  localparam logic [2:0] ERR_NONMIN    = 3'd6;
  localparam logic [2:0] ERR_OVERRUN   = 3'd7;

  // Tag number bits that flag a multi-byte tag, and the long-form marker.
  localparam logic [4:0] TAG_NUM_HIGH  = 5'h1f;
  localparam logic [7:0] LONG_FORM_MIN = 8'h80;

  // Input item as packed in in_tdata (last member in the lowest bits).
  typedef struct packed {
    logic        check_tag;
    logic [7:0]  expected_tag;
    logic [31:0] buffer_size;
    logic [7:0]  data_byte;
  } in_item_t;

  // Result item as packed in out_tdata (last member in the lowest bits).
  typedef struct packed {
    logic [31:0] consumed;
    logic [2:0]  header_length;
    logic [31:0] value_length;
    logic [7:0]  tag;
    logic        tag_mismatch;
    logic [2:0]  error_code;
    logic        ok;
  } result_t;

endpackage

>>> src/der_tlv_header_parser.sv
`timescale 1ns / 1ps
// DER TLV header parser: reads one element byte per word and emits one
// result word per header. Depends on der_tlv_pkg.
//
//  Channel | Direction | Word contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tdata: byte, buffer size, expected tag, check flag;
//          |           | tuser: tag byte that starts a new element
//  out_    | master    | tdata: ok, error code, mismatch, tag, lengths
//
// One word is accepted per cycle; the word that completes the header or
// reveals an error passes through the input register, then the parse
// logic into the result register.
// Only a word that produces a result waits on a full, stalled result
// register; words that produce nothing pass even then.
// Reset clears the header phase and both valid flags; the parser waits for
// a tag byte.
module der_tlv_header_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata, low bit up: data_byte[7:0], buffer_size[39:8],
  // expected_tag[47:40], check_tag[48], zero pad[55:49]
  input  logic [der_tlv_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: first_byte
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata, low bit up: ok[0], error_code[3:1], tag_mismatch[4], tag[12:5],
  // value_length[44:13], header_length[47:45], consumed[79:48]
  output logic [der_tlv_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  // Header phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEN    = 2'd1;
  localparam logic [1:0] PH_LBYTES = 2'd2;

  // Input register.
  logic                  s1_valid_r;
  der_tlv_pkg::in_item_t s1_item_r;
  logic                  s1_first_r;

  // Parser state.
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  tag_hold_r, tag_hold_nxt;
  logic [31:0] size_hold_r, size_hold_nxt;
  logic [7:0]  want_tag_r, want_tag_nxt;
  logic        want_check_r, want_check_nxt;
  logic [2:0]  lb_total_r, lb_total_nxt;
  logic [2:0]  lb_seen_r, lb_seen_nxt;
  logic [31:0] accum_r, accum_nxt;

  // Result register.
  logic                 out_valid_r;
  der_tlv_pkg::result_t out_res_r;

  // Parse signals.
  logic                 emit;
  der_tlv_pkg::result_t res;
  logic                 out_free;
  logic                 s1_go;
  logic [7:0]           b;
  logic [6:0]           count;
  logic [31:0]          acc_shift;
  logic                 acc_nonmin;
  logic [2:0]           seen_inc;
  logic                 use_short;
  logic [31:0]          fin_vlen;
  logic [2:0]           fin_hlen;
  logic [31:0]          room;
  logic                 fin_overrun;
  logic                 fin_mismatch;

  // Handshake: a word moves on unless it must write a full, stalled result.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = !emit || out_free;
  assign in_tready = !s1_valid_r || s1_go;

  assign b          = s1_item_r.data_byte;
  assign count      = b[6:0];
  assign acc_shift  = {accum_r[23:0], b};
  assign acc_nonmin = acc_shift < {24'd0, der_tlv_pkg::LONG_FORM_MIN};
  assign seen_inc   = lb_seen_r + 3'd1;

  // Shared final check, fed by either a short-form byte or the long-form sum.
  assign use_short    = (phase_r == PH_LEN);
  assign fin_vlen     = use_short ? {24'd0, b} : acc_shift;
  assign fin_hlen     = use_short ? 3'd2 : 3'd2 + lb_total_r;
  assign room         = size_hold_r - {29'd0, fin_hlen};
  assign fin_overrun  = fin_vlen > room;
  assign fin_mismatch = want_check_r && (tag_hold_r != want_tag_r);

  // Header parse for the word in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    tag_hold_nxt   = tag_hold_r;
    size_hold_nxt  = size_hold_r;
    want_tag_nxt   = want_tag_r;
    want_check_nxt = want_check_r;
    lb_total_nxt   = lb_total_r;
    lb_seen_nxt    = lb_seen_r;
    accum_nxt      = accum_r;
    emit           = 1'b0;
    res            = '0;
    res.tag        = tag_hold_r;

    if (s1_valid_r) begin
      if (s1_first_r) begin
        // Tag byte: latch the element's settings and check size and tag form.
        tag_hold_nxt   = b;
        size_hold_nxt  = s1_item_r.buffer_size;
        want_tag_nxt   = s1_item_r.expected_tag;
        want_check_nxt = s1_item_r.check_tag;
        lb_total_nxt   = 3'd0;
        lb_seen_nxt    = 3'd0;
        accum_nxt      = 32'd0;
        res.tag        = b;
        phase_nxt      = PH_LEN;
        if (s1_item_r.buffer_size < 32'd2) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_SHORT;
          phase_nxt      = PH_IDLE;
        end else if (b[4:0] == der_tlv_pkg::TAG_NUM_HIGH) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_HIGH_TAG;
          phase_nxt      = PH_IDLE;
        end
      end else if (phase_r == PH_LEN && b[7]) begin
        // Long-form count byte.
        if (count == 7'd0 || count > 7'(MAX_LENGTH_BYTES)) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_COUNT;
          phase_nxt      = PH_IDLE;
        end else if ({1'b0, size_hold_r} < 33'd2 + {26'd0, count}) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_TRUNCATED;
          phase_nxt      = PH_IDLE;
        end else begin
          lb_total_nxt = count[2:0];
          lb_seen_nxt  = 3'd0;
          accum_nxt    = 32'd0;
          phase_nxt    = PH_LBYTES;
        end
      end else if (phase_r == PH_LEN || phase_r == PH_LBYTES) begin
        // Short-form length byte, or one long-form length byte.
        accum_nxt   = acc_shift;
        lb_seen_nxt = seen_inc;
        if (phase_r == PH_LBYTES && lb_seen_r == 3'd0 && b == 8'd0) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_ZERO;
          phase_nxt      = PH_IDLE;
        end else if (phase_r == PH_LBYTES && seen_inc < lb_total_r) begin
          emit = 1'b0;
        end else if (phase_r == PH_LBYTES && acc_nonmin) begin
          emit           = 1'b1;
          res.error_code = der_tlv_pkg::ERR_NONMIN;
          phase_nxt      = PH_IDLE;
        end else begin
          // Length complete: overrun, then tag match.
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          if (fin_overrun) begin
            res.error_code = der_tlv_pkg::ERR_OVERRUN;
          end else begin
            res.value_length  = fin_vlen;
            res.header_length = fin_hlen;
            res.consumed      = fin_vlen + {29'd0, fin_hlen};
            if (fin_mismatch) begin
              res.error_code   = der_tlv_pkg::ERR_OVERRUN;
              res.tag_mismatch = 1'b1;
            end else begin
              res.ok         = 1'b1;
              res.error_code = der_tlv_pkg::ERR_NONE;
            end
          end
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_item_r  <= der_tlv_pkg::in_item_t'(in_tdata[$bits(der_tlv_pkg::in_item_t)-1:0]);
      s1_first_r <= in_tuser;
    end
  end

  // Parser state advances when the registered word moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (s1_valid_r && s1_go) begin
      phase_r <= phase_nxt;
    end
    if (s1_valid_r && s1_go) begin
      tag_hold_r   <= tag_hold_nxt;
      size_hold_r  <= size_hold_nxt;
      want_tag_r   <= want_tag_nxt;
      want_check_r <= want_check_nxt;
      lb_total_r   <= lb_total_nxt;
      lb_seen_r    <= lb_seen_nxt;
      accum_r      <= accum_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (emit && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

>>> src/der_tlv_checker.sv
`timescale 1ns / 1ps
// Port-level checker for der_tlv_header_parser, bound into every instance of it.
// Depends on der_tlv_pkg for the result word layout and error codes.
module der_tlv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic [der_tlv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready
);

  der_tlv_pkg::result_t r;
  assign r = out_tdata;

  // A passing header carries no error and no mismatch.
  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.ok |-> r.error_code == der_tlv_pkg::ERR_NONE && !r.tag_mismatch)
    else $error("ok result carries an error");

  // A mismatch is reported under the overrun/mismatch code.
  a_mismatch_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.tag_mismatch |-> r.error_code == der_tlv_pkg::ERR_OVERRUN)
    else $error("tag mismatch with wrong code");

  // Plain errors zero the length fields.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !r.ok && !r.tag_mismatch |->
      r.value_length == 32'd0 && r.header_length == 3'd0 && r.consumed == 32'd0)
    else $error("error result with nonzero lengths");

  // Consumed is the sum of the two lengths on a decoded header.
  a_consumed_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (r.ok || r.tag_mismatch) |->
      r.consumed == r.value_length + {29'd0, r.header_length} &&
      r.header_length >= 3'd2 && r.header_length <= 3'd6)
    else $error("bad length fields on decoded header");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule

bind der_tlv_header_parser der_tlv_checker u_der_tlv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> tb/der_tlv_header_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for der_tlv_header_parser: drives element bytes, predicts each
// header result in its own model of the parser and compares it field by field.
// Depends on der_tlv_pkg and der_tlv_header_parser.
module der_tlv_header_parser_tb;

  localparam int MAX_LEN_BYTES = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_WORDS  = 500;
  localparam int MAX_REPORTS   = 100;
  localparam int IN_W          = der_tlv_pkg::IN_TDATA_W;
  localparam int OUT_W         = der_tlv_pkg::OUT_TDATA_W;

  typedef enum logic [1:0] {
    HDR_IDLE,
    HDR_LEN,
    HDR_LBYTES
  } hdr_phase_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic [IN_W-1:0]  in_tdata  = '0;
  logic             in_tuser  = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  // Header parser model state.
  hdr_phase_t  phase_q    = HDR_IDLE;
  logic [7:0]  tag_q      = '0;
  logic [31:0] size_q     = '0;
  logic [7:0]  want_tag_q = '0;
  logic        check_q    = 1'b0;
  logic [2:0]  lb_total_q = '0;
  logic [2:0]  lb_seen_q  = '0;
  logic [31:0] accum_q    = '0;

  der_tlv_pkg::result_t expected_headers[$];
  int      err_count    = 0;
  int      words_sent   = 0;
  int      burst_left   = 0;
  bit      no_gaps      = 1'b0;
  int      hold_req     = 0;

  der_tlv_header_parser #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Result for any error other than a tag mismatch: only the tag survives.
  function automatic der_tlv_pkg::result_t error_result(input logic [2:0] code);
    der_tlv_pkg::result_t r;
    r = '0;
    r.error_code = code;
    r.tag = tag_q;
    return r;
  endfunction

  // Length is known: check it against the buffer, then the tag.
  function automatic der_tlv_pkg::result_t finish_header(input logic [31:0] vlen,
                                                         input logic [2:0] hlen);
    der_tlv_pkg::result_t r;
    logic [31:0]          room;
    room = size_q - 32'(hlen);
    if (vlen > room) return error_result(der_tlv_pkg::ERR_OVERRUN);
    r = '0;
    r.tag = tag_q;
    r.value_length = vlen;
    r.header_length = hlen;
    r.consumed = vlen + 32'(hlen);
    if (check_q && tag_q != want_tag_q) begin
      r.error_code = der_tlv_pkg::ERR_OVERRUN;
      r.tag_mismatch = 1'b1;
    end else begin
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // Advances the model by one accepted word; returns 1 when a result is due.
  function automatic bit predict_header_word(input der_tlv_pkg::in_item_t w,
                                             input logic first,
                                             output der_tlv_pkg::result_t r);
    logic [6:0] count;
    r = '0;
    if (first) begin
      tag_q      = w.data_byte;
      size_q     = w.buffer_size;
      want_tag_q = w.expected_tag;
      check_q    = w.check_tag;
      lb_total_q = '0;
      lb_seen_q  = '0;
      accum_q    = '0;
      phase_q    = HDR_IDLE;
      if (size_q < 32'd2) begin
        r = error_result(der_tlv_pkg::ERR_SHORT);
      end else if (tag_q[4:0] == der_tlv_pkg::TAG_NUM_HIGH) begin
        r = error_result(der_tlv_pkg::ERR_HIGH_TAG);
      end else begin
        phase_q = HDR_LEN;
        return 1'b0;
      end
      return 1'b1;
    end
    case (phase_q)
      HDR_LEN: begin
        if (!w.data_byte[7]) begin
          r = finish_header(32'(w.data_byte), 3'd2);
        end else begin
          count = w.data_byte[6:0];
          if (count == 0 || count > MAX_LEN_BYTES) begin
            r = error_result(der_tlv_pkg::ERR_COUNT);
          end else if (size_q < 32'(count) + 32'd2) begin
            r = error_result(der_tlv_pkg::ERR_TRUNCATED);
          end else begin
            lb_total_q = count[2:0];
            lb_seen_q  = '0;
            accum_q    = '0;
            phase_q    = HDR_LBYTES;
            return 1'b0;
          end
        end
      end
      HDR_LBYTES: begin
        if (lb_seen_q == 0 && w.data_byte == 8'h00) begin
          r = error_result(der_tlv_pkg::ERR_ZERO);
        end else begin
          accum_q = {accum_q[23:0], w.data_byte};
          lb_seen_q++;
          if (lb_seen_q < lb_total_q) return 1'b0;
          if (accum_q < 32'(der_tlv_pkg::LONG_FORM_MIN))
            r = error_result(der_tlv_pkg::ERR_NONMIN);
          else r = finish_header(accum_q, 3'd2 + lb_total_q);
        end
      end
      default: return 1'b0;
    endcase
    phase_q = HDR_IDLE;
    return 1'b1;
  endfunction

  // Offers one word in bursts with random gaps; returns just after the accepting edge.
  task automatic send_word(input logic first, input logic [7:0] b, input logic [31:0] size,
                           input logic [7:0] etag, input logic chk);
    der_tlv_pkg::in_item_t item;
    der_tlv_pkg::result_t  r;
    int                    gap;
    item.data_byte    = b;
    item.buffer_size  = size;
    item.expected_tag = etag;
    item.check_tag    = chk;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_tdata  <= IN_W'(item);
    in_tuser  <= first;
    in_tvalid <= 1'b1;
    // Values settle by the falling edge and hold until the next rising edge.
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    words_sent++;
    if (predict_header_word(item, first, r)) expected_headers.push_back(r);
    @(posedge clk);
  endtask

  task automatic send_tag(input logic [7:0] b, input logic [31:0] size,
                          input logic [7:0] etag, input logic chk);
    send_word(1'b1, b, size, etag, chk);
  endtask

  // Continuation byte; the fields sampled only with a tag byte get noise.
  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Sender pauses until every result has come, then lets the pipeline settle.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_headers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One element: mostly a well-formed header, sometimes broken or pure noise.
  task automatic send_random_element();
    logic [7:0]  tag;
    logic [7:0]  etag;
    logic [7:0]  lb[MAX_LEN_BYTES];
    logic        chk;
    logic [31:0] vlen;
    logic [31:0] size;
    logic [32:0] total;
    logic [2:0]  hlen;
    int          n;
    int          pick;
    tag  = 8'($urandom_range(0, 255));
    chk  = 1'($urandom_range(0, 1));
    etag = $urandom_range(0, 1) ? tag : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      n = $urandom_range(0, 1) ? $urandom_range(1, MAX_LEN_BYTES) : 0;
      if (n == 0) begin
        vlen = $urandom_range(0, 127);
        hlen = 3'd2;
      end else begin
        vlen = '0;
        for (int i = 0; i < n; i++) begin
          lb[i] = 8'($urandom_range(0, 255));
          // Keep the encoding minimal: nonzero lead byte, one-byte form at least 0x80.
          if (i == 0) begin
            lb[i] = (n == 1) ? (lb[i] | der_tlv_pkg::LONG_FORM_MIN)
                             : ((lb[i] == 0) ? 8'h01 : lb[i]);
          end
          vlen = {vlen[23:0], lb[i]};
        end
        hlen = 3'(2 + n);
      end
      total = 33'(vlen) + 33'(hlen);
      case ($urandom_range(0, 3))
        0: size = total[32] ? 32'hffff_ffff : total[31:0];
        1: begin
          total = total + 33'($urandom_range(1, 1000));
          size = total[32] ? 32'hffff_ffff : total[31:0];
        end
        2: size = total[31:0] - 32'd1;
        default: size = $urandom;
      endcase
      send_tag(tag, size, etag, chk);
      if (n == 0) begin
        send_byte(vlen[7:0]);
      end else begin
        send_byte(der_tlv_pkg::LONG_FORM_MIN | 8'(n));
        for (int i = 0; i < n; i++) send_byte(lb[i]);
      end
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 9) begin
      send_tag(tag, $urandom, etag, chk);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stray byte before any element, and a buffer too small for a header.
  task automatic test_idle_and_short_buffer();
    send_byte(8'hff);
    send_tag(8'h00, 32'd0, 8'h00, 1'b0);
  endtask

  // Multi-byte tag, exact-fit short form with a matching tag, a mismatching tag.
  task automatic test_tag_checks();
    send_tag(8'h1f, 32'hffff_ffff, 8'h1f, 1'b1);
    send_tag(8'h02, 32'd2, 8'h02, 1'b1);
    send_byte(8'h00);
    // Value byte after the result is ignored.
    send_byte(8'h55);
    send_tag(8'h30, 32'hffff_ffff, 8'hff, 1'b1);
    send_byte(8'h7f);
  endtask

  // Each length error in turn, then a maximal length that overruns the largest buffer.
  task automatic test_length_errors();
    send_tag(8'h10, 32'd100, 8'h00, 1'b0);
    send_byte(8'h80);
    send_tag(8'h10, 32'd5, 8'h00, 1'b0);
    send_byte(8'h84);
    send_tag(8'h10, 32'd100, 8'h00, 1'b0);
    send_byte(8'h82);
    send_byte(8'h00);
    send_tag(8'h10, 32'd100, 8'h00, 1'b0);
    send_byte(8'h81);
    send_byte(8'h7f);
    send_tag(8'hf0, 32'hffff_ffff, 8'h00, 1'b0);
    send_byte(8'h84);
    repeat (4) send_byte(8'hff);
  endtask

  // A new tag byte in the middle of a header drops the element in progress.
  task automatic test_restart_mid_header();
    send_tag(8'h04, 32'd1000, 8'h00, 1'b0);
    send_byte(8'h82);
    send_tag(8'h05, 32'd1000, 8'h05, 1'b1);
    send_byte(8'h81);
    send_byte(8'h80);
  endtask

  // Receiver holds off while the sender keeps offering back-to-back words.
  task automatic test_output_backpressure();
    hold_req = 100;
    no_gaps = 1'b1;
    repeat (15) send_random_element();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_elements();
    int start;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) send_random_element();
  endtask

  // Receiver: random stall patterns in segments, plus a long hold on request.
  initial begin : result_stall
    int hold_left;
    int seg_left;
    int seg_mode;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (seg_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(negedge clk) begin : result_check
    der_tlv_pkg::result_t seen;
    der_tlv_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = der_tlv_pkg::result_t'(out_tdata);
      if (expected_headers.size() == 0) begin
        report_error($sformatf("result word with nothing expected: 0x%0h", out_tdata));
      end else begin
        want = expected_headers.pop_front();
        if (seen.ok !== want.ok)
          report_error($sformatf("ok: got %0b, expected %0b", seen.ok, want.ok));
        if (seen.error_code !== want.error_code)
          report_error($sformatf("error_code: got %0d, expected %0d",
                                 seen.error_code, want.error_code));
        if (seen.tag_mismatch !== want.tag_mismatch)
          report_error($sformatf("tag_mismatch: got %0b, expected %0b",
                                 seen.tag_mismatch, want.tag_mismatch));
        if (seen.tag !== want.tag)
          report_error($sformatf("tag: got 0x%0h, expected 0x%0h", seen.tag, want.tag));
        if (seen.value_length !== want.value_length)
          report_error($sformatf("value_length: got 0x%0h, expected 0x%0h",
                                 seen.value_length, want.value_length));
        if (seen.header_length !== want.header_length)
          report_error($sformatf("header_length: got %0d, expected %0d",
                                 seen.header_length, want.header_length));
        if (seen.consumed !== want.consumed)
          report_error($sformatf("consumed: got 0x%0h, expected 0x%0h",
                                 seen.consumed, want.consumed));
      end
    end
  end

  // Watchdog: too many cycles in a row without a word moving on either side.
  initial begin : idle_watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
    $display("FAIL der_tlv_header_parser");
    $finish;
  end

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_short_buffer();
    test_tag_checks();
    test_length_errors();
    test_restart_mid_header();
    wait_for_results();
    test_output_backpressure();
    wait_for_results();
    test_random_elements();
    wait_for_results();
    if (err_count == 0) begin
      $display("PASS der_tlv_header_parser");
    end else begin
      $display("FAIL der_tlv_header_parser");
    end
    $finish;
  end

endmodule

>>> files.f
src/der_tlv_pkg.sv
src/der_tlv_header_parser.sv
src/der_tlv_checker.sv
tb/der_tlv_header_parser_tb.sv
